[src/histeq_pkg.sv]
`default_nettype none

package histeq_pkg;

  localparam int LEVELS     = 256;
  localparam int MAX_PIXELS = 1048576;

  localparam int LVL_W   = $clog2(LEVELS);
  localparam int OP_W    = 2;
  localparam int PIX_W   = 8;
  localparam int CFG_W   = 21;
  localparam int OUT_W   = 8;
  localparam int COUNT_W = $clog2(2 * MAX_PIXELS);
  localparam int NUM_W   = COUNT_W + 10;
  localparam int DEN_W   = CFG_W + 1;
  localparam int QCNT_W  = $clog2(OUT_W);

  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(2 * MAX_PIXELS - 1);
  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(262144);
  localparam logic [OUT_W-1:0]   OUT_MAX   = OUT_W'(255);
  localparam int                 SCALE     = 2 * 255;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_COUNT = 2'd1,
    OP_BUILD = 2'd2,
    OP_MAP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ACC,
    ST_SCALE,
    ST_START,
    ST_DIV
  } build_state_e;

  typedef struct packed {
    logic             clear;
    logic             count;
    logic             read;
    logic [LVL_W-1:0] addr;
  } hist_req_t;

endpackage

`default_nettype wire

[src/histeq_if.sv]
`default_nettype none

interface histeq_req_if;
  logic                            valid;
  logic                            ready;
  logic [histeq_pkg::OP_W-1:0]     operation;
  logic [histeq_pkg::PIX_W-1:0]    pixel_value;

  modport source (output valid, output operation, output pixel_value, input ready);
  modport sink (input valid, input operation, input pixel_value, output ready);
endinterface

interface histeq_res_if;
  logic                            valid;
  logic                            ready;
  logic [histeq_pkg::OUT_W-1:0]    equalized_value;

  modport source (output valid, output equalized_value, input ready);
  modport sink (input valid, input equalized_value, output ready);
endinterface

interface histeq_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [histeq_pkg::CFG_W-1:0]    image_pixels;

  modport source (output valid, output image_pixels, input ready);
  modport sink (input valid, input image_pixels, output ready);
endinterface

`default_nettype wire

[src/histeq_ram.sv]
`default_nettype none

module histeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[src/histeq_hist.sv]
`default_nettype none

module histeq_hist (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  histeq_pkg::hist_req_t          req_i,
  output logic [histeq_pkg::COUNT_W-1:0] rd_data_o
);
  import histeq_pkg::*;

  logic [LEVELS-1:0]  vld_q;
  logic               s2_vld_q;
  logic [LVL_W-1:0]   s2_addr_q;
  logic               snap_q;
  logic               fwd_vld_q;
  logic [LVL_W-1:0]   fwd_addr_q;
  logic [COUNT_W-1:0] fwd_val_q;
  logic [COUNT_W-1:0] ram_rdata;
  logic [COUNT_W-1:0] old_val;
  logic [COUNT_W-1:0] new_val;

  // a bin never written since the last clear reads as zero
  assign rd_data_o = snap_q ? ram_rdata : '0;

  // the previous count writes at the edge this one reads: take its value
  assign old_val = (fwd_vld_q && (fwd_addr_q == s2_addr_q)) ? fwd_val_q : rd_data_o;
  assign new_val = (old_val == COUNT_MAX) ? old_val : old_val + COUNT_W'(1);

  histeq_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (LEVELS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (s2_vld_q),
    .waddr_i (s2_addr_q),
    .wdata_i (new_val),
    .re_i    (req_i.count || req_i.read),
    .raddr_i (req_i.addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      s2_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= req_i.count;
      // clear lands after any write still in flight
      if (req_i.clear) begin
        vld_q     <= '0;
        fwd_vld_q <= 1'b0;
      end else if (s2_vld_q) begin
        vld_q[s2_addr_q] <= 1'b1;
        fwd_vld_q        <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.count) begin
      s2_addr_q <= req_i.addr;
    end
    if (req_i.count || req_i.read) begin
      snap_q <= vld_q[req_i.addr];
    end
    if (s2_vld_q) begin
      fwd_addr_q <= s2_addr_q;
      fwd_val_q  <= new_val;
    end
  end

endmodule

`default_nettype wire

[src/histeq_div.sv]
`default_nettype none

module histeq_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [histeq_pkg::NUM_W-1:0] num_i,
  input  logic [histeq_pkg::DEN_W-1:0] den_i,
  output logic                         done_o,
  output logic [histeq_pkg::OUT_W-1:0] quo_o
);
  import histeq_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic              sat_q;
  logic [NUM_W-1:0]  rem_q;
  logic [NUM_W-1:0]  dsh_q;
  logic [QCNT_W-1:0] cnt_q;
  logic [OUT_W-1:0]  quo_q;
  logic              ge;

  assign ge     = rem_q >= dsh_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= QCNT_W'(OUT_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - QCNT_W'(1);
        if (sat_q || (cnt_q == '0)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= NUM_W'({den_i, {(OUT_W - 1){1'b0}}});
      // quotient would not fit in the output: clamp
      sat_q <= num_i >= NUM_W'({den_i, {OUT_W{1'b0}}});
    end else if (busy_q) begin
      if (sat_q) begin
        quo_q <= OUT_MAX;
      end else begin
        if (ge) begin
          rem_q <= rem_q - dsh_q;
        end
        dsh_q <= dsh_q >> 1;
        quo_q <= {quo_q[OUT_W-2:0], ge};
      end
    end
  end

endmodule

`default_nettype wire

[src/histogram_equalization.sv]
// Count, clear and map requests are taken one per cycle while no build runs and the output
// queue has room; a map result is registered from the table read, then waits in a two-entry queue.
// Build walks the bins through the bin memory read port and a bit-serial divider, reading,
// accumulating, scaling and dividing each bin in turn (the divider stops early where the
// level clamps); no request is taken meanwhile. Reset empties the histogram at once through
// per-bin valid flags, sets image_pixels to 262144; the table holds nothing until the first build.
`default_nettype none

module histogram_equalization (
  input  logic          clk_i,
  input  logic          rst_ni,
  histeq_req_if.sink    req_i,
  histeq_res_if.source  res_o,
  histeq_cfg_if.sink    cfg_i
);
  import histeq_pkg::*;

  build_state_e       state_q, state_d;
  logic [CFG_W-1:0]   img_pix_q;
  logic [LVL_W-1:0]   bin_q;
  logic [COUNT_W-1:0] sum_q, sum_d;
  logic [NUM_W-1:0]   num_q, num_d;
  logic [COUNT_W:0]   sum_wide;
  logic [CFG_W-1:0]   pix_eff;
  logic [DEN_W-1:0]   den;

  op_e                op;
  logic               accept;
  logic               pix_in;
  logic [LVL_W-1:0]   pix_addr;
  logic               idle;
  logic               rd_en;
  logic               div_start;
  logic               tbl_we;
  logic               div_done;
  logic [OUT_W-1:0]   div_quo;

  hist_req_t          hreq;
  logic [COUNT_W-1:0] bin_data;

  logic               m_vld_q;
  logic               m_in_q;
  logic [OUT_W-1:0]   tbl_rdata;
  logic [OUT_W-1:0]   fifo_q [2];
  logic               wr_ptr_q;
  logic               rd_ptr_q;
  logic [1:0]         cnt_q, cnt_d;
  logic [1:0]         occ;
  logic               push;
  logic               pop;
  logic               map_space;

  assign op       = op_e'(req_i.operation);
  assign accept   = req_i.valid && req_i.ready;
  assign pix_in   = int'(req_i.pixel_value) < LEVELS;
  assign pix_addr = LVL_W'(req_i.pixel_value);

  // FSM: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (op == OP_BUILD)) begin
          state_d = ST_READ;
        end
      end
      ST_READ:  state_d = ST_ACC;
      ST_ACC:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = (bin_q == LVL_W'(LEVELS - 1)) ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // FSM: outputs
  always_comb begin
    idle      = 1'b0;
    rd_en     = 1'b0;
    div_start = 1'b0;
    tbl_we    = 1'b0;
    case (state_q)
      ST_IDLE:  idle      = 1'b1;
      ST_READ:  rd_en     = 1'b1;
      ST_START: div_start = 1'b1;
      ST_DIV:   tbl_we    = div_done;
      default: ;
    endcase
  end

  // saturating running sum and the scaled numerator 2*s*255 + p
  assign sum_wide = {1'b0, sum_q} + {1'b0, bin_data};
  assign sum_d    = (sum_wide > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum_wide[COUNT_W-1:0];
  assign pix_eff  = (img_pix_q == '0) ? CFG_W'(1) : img_pix_q;
  assign den      = {pix_eff, 1'b0};
  assign num_d    = NUM_W'(sum_q) * NUM_W'(SCALE) + NUM_W'(pix_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      img_pix_q <= CFG_RESET;
      bin_q     <= '0;
      sum_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        img_pix_q <= cfg_i.image_pixels;
      end
      if (accept && ((op == OP_CLEAR) || (op == OP_BUILD))) begin
        sum_q <= '0;
        bin_q <= '0;
      end
      if (state_q == ST_ACC) begin
        sum_q <= sum_d;
      end
      if (tbl_we) begin
        bin_q <= bin_q + LVL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCALE) begin
      num_q <= num_d;
    end
  end

  assign hreq.clear = accept && (op == OP_CLEAR);
  assign hreq.count = accept && (op == OP_COUNT) && pix_in;
  assign hreq.read  = rd_en;
  assign hreq.addr  = rd_en ? bin_q : pix_addr;

  histeq_hist u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (hreq),
    .rd_data_o (bin_data)
  );

  histeq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  histeq_ram #(
    .WIDTH (OUT_W),
    .DEPTH (LEVELS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (bin_q),
    .wdata_i (div_quo),
    .re_i    (accept && (op == OP_MAP)),
    .raddr_i (pix_addr),
    .rdata_o (tbl_rdata)
  );

  // output queue: hold a map slot only when a free entry is certain
  assign push      = m_vld_q;
  assign pop       = res_o.valid && res_o.ready;
  assign occ       = cnt_q + {1'b0, m_vld_q};
  assign map_space = (occ != 2'd2) || pop;

  always_comb begin
    cnt_d = cnt_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q  <= 1'b0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      m_vld_q <= accept && (op == OP_MAP);
      cnt_q   <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (op == OP_MAP)) begin
      m_in_q <= pix_in;
    end
    if (push) begin
      fifo_q[wr_ptr_q] <= m_in_q ? tbl_rdata : '0;
    end
  end

  assign req_i.ready           = idle && map_space;
  assign res_o.valid           = cnt_q != 2'd0;
  assign res_o.equalized_value = fifo_q[rd_ptr_q];
  assign cfg_i.ready           = 1'b1;

endmodule

`default_nettype wire
